>>> src/vrd_pkg.sv
// Shared definitions for the VGA register file and palette DAC.
// Port offsets, bank codes, bank depths and the register memory request type.
// No dependencies.
package vrd_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int DATA_W    = 8;
  localparam int RB_IDX_W  = 5;
  localparam int RB_BANK_W = 2;
  localparam int RB_ADDR_W = RB_BANK_W + RB_IDX_W;
  localparam int PAL_W     = 18;
  localparam int COMP_W    = 6;

  // port offsets from 0x3C0
  localparam logic [4:0] PORT_ATTR      = 5'h00;
  localparam logic [4:0] PORT_ATTR_RD   = 5'h01;
  localparam logic [4:0] PORT_MISC_WR   = 5'h02;
  localparam logic [4:0] PORT_SEQ_IDX   = 5'h04;
  localparam logic [4:0] PORT_SEQ_DATA  = 5'h05;
  localparam logic [4:0] PORT_DAC_RIDX  = 5'h07;
  localparam logic [4:0] PORT_DAC_WIDX  = 5'h08;
  localparam logic [4:0] PORT_DAC_DATA  = 5'h09;
  localparam logic [4:0] PORT_MISC_RD   = 5'h0C;
  localparam logic [4:0] PORT_GFX_IDX   = 5'h0E;
  localparam logic [4:0] PORT_GFX_DATA  = 5'h0F;
  localparam logic [4:0] PORT_CRTC_IDX  = 5'h14;
  localparam logic [4:0] PORT_CRTC_DATA = 5'h15;
  localparam logic [4:0] PORT_STATUS    = 5'h1A;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // bank codes form the top bits of the register memory address
  localparam logic [RB_BANK_W-1:0] BANK_ATTR = 2'd0;
  localparam logic [RB_BANK_W-1:0] BANK_SEQ  = 2'd1;
  localparam logic [RB_BANK_W-1:0] BANK_GFX  = 2'd2;
  localparam logic [RB_BANK_W-1:0] BANK_CRTC = 2'd3;

  localparam logic [7:0] SEQ_DEPTH  = 8'd5;
  localparam logic [7:0] CRTC_DEPTH = 8'd25;
  localparam logic [7:0] GFX_DEPTH  = 8'd9;
  localparam logic [4:0] ATTR_DEPTH = 5'd21;

  localparam logic [7:0] CRTC_PROTECT_REG = 8'h11;
  localparam logic [7:0] CRTC_PROT_LIMIT  = 8'd8;
  localparam int         CRTC_PROTECT_BIT = 7;

  localparam logic [1:0] PHASE_RED   = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_BLUE  = 2'd2;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [RB_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]    wdata;
  } rb_req_t;

  // byte reduced modulo the palette depth; depth >= 16 so the quotient fits 4 bits
  function automatic logic [7:0] entry_mod(logic [7:0] v, int entries);
    logic [11:0] r;
    r = {4'd0, v};
    for (int s = 3; s >= 0; s--) begin
      if (r >= 12'(entries << s)) begin
        r = r - 12'(entries << s);
      end
    end
    return r[7:0];
  endfunction

endpackage

>>> src/vrd_regbank.sv
// Register memory for the sequencer, CRTC, graphics and attribute banks.
// Synchronous single-port store with per-entry valid bits so reset reads as zero.
// Depends on vrd_pkg.
module vrd_regbank (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vrd_pkg::rb_req_t            req,
  output logic [vrd_pkg::DATA_W-1:0]  rdata
);

  localparam int DEPTH = 1 << vrd_pkg::RB_ADDR_W;

  logic [vrd_pkg::DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid_r;
  logic [vrd_pkg::DATA_W-1:0] rdata_r;
  logic                       rvalid_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r  <= mem[req.addr];
      rvalid_r <= valid_r[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  // never-written entries hold their reset value of zero
  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

>>> src/vrd_palette.sv
// Palette store of 18-bit RGB entries, one synchronous read or write port.
// Depends on vrd_pkg.
module vrd_palette #(
  parameter int ENTRIES = vrd_pkg::PALETTE_ENTRIES_DEF,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [AW-1:0]              addr,
  input  logic [vrd_pkg::PAL_W-1:0]  wdata,
  output logic [vrd_pkg::PAL_W-1:0]  rdata
);

  logic [vrd_pkg::PAL_W-1:0] mem [ENTRIES];
  logic [vrd_pkg::PAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/vga_register_file_and_dac_core.sv
// Top level of the VGA register front end: port decode, index registers, DAC sequencing.
// Depends on vrd_pkg, vrd_regbank and vrd_palette.
//
// One I/O port access per input transaction, one result per access. The accept
// cycle decodes the port, updates the index, flip-flop and DAC pointer registers and
// issues at most one read or write to the register memory or the palette memory; the
// execute state picks the byte from the registered memory data and loads the output
// register. A new access is taken only in the idle state, after the last result has
// been loaded; a stalled result holds the block in its execute state.
// Bank registers clear at reset through valid bits; palette entries are undefined
// until written, and there is no clearing pass.
module vga_register_file_and_dac_core #(
  parameter int PALETTE_ENTRIES = vrd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind[0], port[5:1], write_data[13:6], zero[15:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0], display_enabled[8], zero[15:9]
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam logic [PAL_AW-1:0] LAST_ENTRY = PAL_AW'(PALETTE_ENTRIES - 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;
  typedef enum logic [1:0] {SRC_IMM, SRC_REG, SRC_PAL} src_t;

  state_t state_r;
  logic   out_tvalid_r;
  logic [15:0] out_tdata_r;

  // architectural registers
  logic [7:0]  misc_r, misc_nxt;
  logic [7:0]  seq_idx_r, seq_idx_nxt;
  logic [7:0]  gfx_idx_r, gfx_idx_nxt;
  logic [7:0]  crtc_idx_r, crtc_idx_nxt;
  logic [5:0]  attr_idx_r, attr_idx_nxt;
  logic        attr_flip_r, attr_flip_nxt;
  logic        crtc_prot_r, crtc_prot_nxt;
  logic [PAL_AW-1:0] wr_entry_r, wr_entry_nxt;
  logic [PAL_AW-1:0] rd_entry_r, rd_entry_nxt;
  logic [1:0]  wr_phase_r, wr_phase_nxt;
  logic [1:0]  rd_phase_r, rd_phase_nxt;
  logic [11:0] staging_r, staging_nxt;

  // per-access result selection, held for the execute state
  src_t        src_r, src_nxt;
  logic [7:0]  imm_r, imm_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic        disp_r;

  vrd_pkg::rb_req_t rb_req;
  logic [7:0]        rb_rdata;
  logic              pal_we, pal_re;
  logic [PAL_AW-1:0] pal_addr;
  logic [vrd_pkg::PAL_W-1:0] pal_wdata, pal_rdata;

  logic       accept;
  logic       kind;
  logic [4:0] port;
  logic [7:0] wd;
  logic [7:0] wd_mod;
  logic [7:0] rd_byte;
  logic [vrd_pkg::COMP_W-1:0] comp_val;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign kind      = in_tdata[0];
  assign port      = in_tdata[5:1];
  assign wd        = in_tdata[13:6];
  assign wd_mod    = vrd_pkg::entry_mod(wd, PALETTE_ENTRIES);

  always_comb begin
    misc_nxt      = misc_r;
    seq_idx_nxt   = seq_idx_r;
    gfx_idx_nxt   = gfx_idx_r;
    crtc_idx_nxt  = crtc_idx_r;
    attr_idx_nxt  = attr_idx_r;
    attr_flip_nxt = attr_flip_r;
    crtc_prot_nxt = crtc_prot_r;
    wr_entry_nxt  = wr_entry_r;
    rd_entry_nxt  = rd_entry_r;
    wr_phase_nxt  = wr_phase_r;
    rd_phase_nxt  = rd_phase_r;
    staging_nxt   = staging_r;
    src_nxt       = SRC_IMM;
    imm_nxt       = '0;
    comp_nxt      = rd_phase_r;
    rb_req        = '0;
    rb_req.wdata  = wd;
    pal_we        = 1'b0;
    pal_re        = 1'b0;
    pal_wdata     = {staging_r[5:0], staging_r[11:6], wd[5:0]};

    if (accept && kind == vrd_pkg::KIND_WRITE) begin
      case (port)
        vrd_pkg::PORT_ATTR: begin
          if (!attr_flip_r) begin
            attr_idx_nxt  = wd[5:0];
            attr_flip_nxt = 1'b1;
          end else begin
            attr_flip_nxt = 1'b0;
            if (attr_idx_r[4:0] < vrd_pkg::ATTR_DEPTH) begin
              rb_req.we   = 1'b1;
              rb_req.addr = {vrd_pkg::BANK_ATTR, attr_idx_r[4:0]};
            end
          end
        end
        vrd_pkg::PORT_MISC_WR: misc_nxt = wd;
        vrd_pkg::PORT_SEQ_IDX: seq_idx_nxt = wd;
        vrd_pkg::PORT_SEQ_DATA: begin
          if (seq_idx_r < vrd_pkg::SEQ_DEPTH) begin
            rb_req.we   = 1'b1;
            rb_req.addr = {vrd_pkg::BANK_SEQ, seq_idx_r[4:0]};
          end
        end
        vrd_pkg::PORT_DAC_RIDX: begin
          rd_entry_nxt = wd_mod[PAL_AW-1:0];
          rd_phase_nxt = vrd_pkg::PHASE_RED;
        end
        vrd_pkg::PORT_DAC_WIDX: begin
          wr_entry_nxt = wd_mod[PAL_AW-1:0];
          wr_phase_nxt = vrd_pkg::PHASE_RED;
        end
        vrd_pkg::PORT_DAC_DATA: begin
          case (wr_phase_r)
            vrd_pkg::PHASE_RED: begin
              staging_nxt[5:0] = wd[5:0];
              wr_phase_nxt     = vrd_pkg::PHASE_GREEN;
            end
            vrd_pkg::PHASE_GREEN: begin
              staging_nxt[11:6] = wd[5:0];
              wr_phase_nxt      = vrd_pkg::PHASE_BLUE;
            end
            default: begin
              pal_we       = 1'b1;
              wr_entry_nxt = (wr_entry_r == LAST_ENTRY) ? '0 : wr_entry_r + 1'b1;
              wr_phase_nxt = vrd_pkg::PHASE_RED;
            end
          endcase
        end
        vrd_pkg::PORT_GFX_IDX: gfx_idx_nxt = wd;
        vrd_pkg::PORT_GFX_DATA: begin
          if (gfx_idx_r < vrd_pkg::GFX_DEPTH) begin
            rb_req.we   = 1'b1;
            rb_req.addr = {vrd_pkg::BANK_GFX, gfx_idx_r[4:0]};
          end
        end
        vrd_pkg::PORT_CRTC_IDX: crtc_idx_nxt = wd;
        vrd_pkg::PORT_CRTC_DATA: begin
          if (crtc_idx_r < vrd_pkg::CRTC_DEPTH &&
              !(crtc_prot_r && crtc_idx_r < vrd_pkg::CRTC_PROT_LIMIT)) begin
            rb_req.we   = 1'b1;
            rb_req.addr = {vrd_pkg::BANK_CRTC, crtc_idx_r[4:0]};
            // shadow of the protect bit so the lock needs no memory read
            if (crtc_idx_r == vrd_pkg::CRTC_PROTECT_REG) begin
              crtc_prot_nxt = wd[vrd_pkg::CRTC_PROTECT_BIT];
            end
          end
        end
        default: ;
      endcase
    end else if (accept) begin
      case (port)
        vrd_pkg::PORT_ATTR: imm_nxt = {2'b00, attr_idx_r};
        vrd_pkg::PORT_ATTR_RD: begin
          if (attr_idx_r[4:0] < vrd_pkg::ATTR_DEPTH) begin
            rb_req.re   = 1'b1;
            rb_req.addr = {vrd_pkg::BANK_ATTR, attr_idx_r[4:0]};
            src_nxt     = SRC_REG;
          end
        end
        vrd_pkg::PORT_SEQ_IDX: imm_nxt = seq_idx_r;
        vrd_pkg::PORT_SEQ_DATA: begin
          if (seq_idx_r < vrd_pkg::SEQ_DEPTH) begin
            rb_req.re   = 1'b1;
            rb_req.addr = {vrd_pkg::BANK_SEQ, seq_idx_r[4:0]};
            src_nxt     = SRC_REG;
          end
        end
        vrd_pkg::PORT_DAC_WIDX: imm_nxt = 8'(wr_entry_r);
        vrd_pkg::PORT_DAC_DATA: begin
          pal_re  = 1'b1;
          src_nxt = SRC_PAL;
          case (rd_phase_r)
            vrd_pkg::PHASE_RED:   rd_phase_nxt = vrd_pkg::PHASE_GREEN;
            vrd_pkg::PHASE_GREEN: rd_phase_nxt = vrd_pkg::PHASE_BLUE;
            default: begin
              rd_phase_nxt = vrd_pkg::PHASE_RED;
              rd_entry_nxt = (rd_entry_r == LAST_ENTRY) ? '0 : rd_entry_r + 1'b1;
            end
          endcase
        end
        vrd_pkg::PORT_MISC_RD: imm_nxt = misc_r;
        vrd_pkg::PORT_GFX_IDX: imm_nxt = gfx_idx_r;
        vrd_pkg::PORT_GFX_DATA: begin
          if (gfx_idx_r < vrd_pkg::GFX_DEPTH) begin
            rb_req.re   = 1'b1;
            rb_req.addr = {vrd_pkg::BANK_GFX, gfx_idx_r[4:0]};
            src_nxt     = SRC_REG;
          end
        end
        vrd_pkg::PORT_CRTC_IDX: imm_nxt = crtc_idx_r;
        vrd_pkg::PORT_CRTC_DATA: begin
          if (crtc_idx_r < vrd_pkg::CRTC_DEPTH) begin
            rb_req.re   = 1'b1;
            rb_req.addr = {vrd_pkg::BANK_CRTC, crtc_idx_r[4:0]};
            src_nxt     = SRC_REG;
          end
        end
        vrd_pkg::PORT_STATUS: attr_flip_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  assign pal_addr = pal_we ? wr_entry_r : rd_entry_r;

  vrd_regbank u_regbank (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rb_req),
    .rdata (rb_rdata)
  );

  vrd_palette #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (PAL_AW)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .re    (pal_re),
    .addr  (pal_addr),
    .wdata (pal_wdata),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      misc_r      <= '0;
      seq_idx_r   <= '0;
      gfx_idx_r   <= '0;
      crtc_idx_r  <= '0;
      attr_idx_r  <= '0;
      attr_flip_r <= 1'b0;
      crtc_prot_r <= 1'b0;
      wr_entry_r  <= '0;
      rd_entry_r  <= '0;
      wr_phase_r  <= vrd_pkg::PHASE_RED;
      rd_phase_r  <= vrd_pkg::PHASE_RED;
      staging_r   <= '0;
    end else begin
      misc_r      <= misc_nxt;
      seq_idx_r   <= seq_idx_nxt;
      gfx_idx_r   <= gfx_idx_nxt;
      crtc_idx_r  <= crtc_idx_nxt;
      attr_idx_r  <= attr_idx_nxt;
      attr_flip_r <= attr_flip_nxt;
      crtc_prot_r <= crtc_prot_nxt;
      wr_entry_r  <= wr_entry_nxt;
      rd_entry_r  <= rd_entry_nxt;
      wr_phase_r  <= wr_phase_nxt;
      rd_phase_r  <= rd_phase_nxt;
      staging_r   <= staging_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_r  <= src_nxt;
      imm_r  <= imm_nxt;
      comp_r <= comp_nxt;
      disp_r <= attr_idx_nxt[5];
    end
  end

  always_comb begin
    case (comp_r)
      vrd_pkg::PHASE_RED:   comp_val = pal_rdata[17:12];
      vrd_pkg::PHASE_GREEN: comp_val = pal_rdata[11:6];
      default:              comp_val = pal_rdata[5:0];
    endcase
    case (src_r)
      SRC_REG: rd_byte = rb_rdata;
      SRC_PAL: rd_byte = {2'b00, comp_val};
      default: rd_byte = imm_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_tvalid_r && out_tready) begin
            out_tvalid_r <= 1'b0;
          end
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // load when the output register is empty or draining this cycle
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'd0, disp_r, rd_byte};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted transaction did not enter execute");

  a_wr_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_phase_r <= vrd_pkg::PHASE_BLUE)
    else $error("DAC write phase out of range");

  a_rd_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_phase_r <= vrd_pkg::PHASE_BLUE)
    else $error("DAC read phase out of range");

  a_status_clears_flip: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == vrd_pkg::KIND_READ && port == vrd_pkg::PORT_STATUS |=> !attr_flip_r)
    else $error("status read left attribute flip-flop set");

  a_single_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(pal_we && pal_re) && !(rb_req.we && rb_req.re) && !((pal_we || pal_re) && rb_req.re))
    else $error("more than one memory operation in one access");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking bench for vga_register_file_and_dac_core: random and directed port accesses
// are predicted by a scoreboard class and compared with each returned result.
// Depends on vrd_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_N        = 256;
  localparam int ITEMS        = 650;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 12;
  localparam int TIMEOUT_NS   = 400_000;
  localparam int MAX_PRINTED  = 30;
  localparam int SEQ_N        = vrd_pkg::SEQ_DEPTH;
  localparam int CRTC_N       = vrd_pkg::CRTC_DEPTH;
  localparam int GFX_N        = vrd_pkg::GFX_DEPTH;
  localparam int ATTR_N       = vrd_pkg::ATTR_DEPTH;
  // a port with nothing behind it
  localparam logic [4:0] PORT_UNMAPPED = 5'h1F;

  typedef struct packed {
    logic [7:0] read_data;
    logic       display_enabled;
  } port_result_t;

  typedef enum int {
    PAT_SEQ_BANK,
    PAT_GFX_BANK,
    PAT_CRTC_BANK,
    PAT_ATTR,
    PAT_DAC_LOAD,
    PAT_DAC_FETCH,
    PAT_MISC
  } access_pattern_t;

  class port_scoreboard;
    logic [7:0]  misc_reg;
    logic [7:0]  seq_regs [SEQ_N];
    logic [7:0]  crtc_regs [CRTC_N];
    logic [7:0]  gfx_regs [GFX_N];
    logic [7:0]  attr_regs [ATTR_N];
    logic [7:0]  seq_idx, crtc_idx, gfx_idx;
    logic [5:0]  attr_idx;
    logic        attr_flip;
    int          dac_wr_entry, dac_rd_entry;
    logic [1:0]  dac_wr_phase, dac_rd_phase;
    logic [11:0] staging;
    logic [17:0] palette [PAL_N];
    bit          pal_valid [PAL_N];
    int          loaded_q[$];
    port_result_t expected_q[$];
    int          errors;
    int          checked;

    function new();
      misc_reg = '0;
      foreach (seq_regs[i]) seq_regs[i] = '0;
      foreach (crtc_regs[i]) crtc_regs[i] = '0;
      foreach (gfx_regs[i]) gfx_regs[i] = '0;
      foreach (attr_regs[i]) attr_regs[i] = '0;
      foreach (palette[i]) begin
        palette[i] = '0;
        pal_valid[i] = 1'b0;
      end
      seq_idx = '0;
      crtc_idx = '0;
      gfx_idx = '0;
      attr_idx = '0;
      attr_flip = 1'b0;
      dac_wr_entry = 0;
      dac_rd_entry = 0;
      dac_wr_phase = vrd_pkg::PHASE_RED;
      dac_rd_phase = vrd_pkg::PHASE_RED;
      staging = '0;
      errors = 0;
      checked = 0;
    endfunction

    task log_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch %0d: %s", $realtime, errors, msg);
    endtask

    // a DAC read is only safe once the entry it points at has been loaded
    function bit fetch_ok();
      return pal_valid[dac_rd_entry];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void dac_load(logic [5:0] c);
      case (dac_wr_phase)
        vrd_pkg::PHASE_RED: begin
          staging[5:0] = c;
          dac_wr_phase = vrd_pkg::PHASE_GREEN;
        end
        vrd_pkg::PHASE_GREEN: begin
          staging[11:6] = c;
          dac_wr_phase = vrd_pkg::PHASE_BLUE;
        end
        default: begin
          palette[dac_wr_entry] = {staging[5:0], staging[11:6], c};
          if (!pal_valid[dac_wr_entry]) begin
            pal_valid[dac_wr_entry] = 1'b1;
            loaded_q.push_back(dac_wr_entry);
          end
          dac_wr_entry = (dac_wr_entry + 1) % PAL_N;
          dac_wr_phase = vrd_pkg::PHASE_RED;
        end
      endcase
    endfunction

    function logic [7:0] dac_fetch();
      logic [17:0] ent;
      logic [7:0]  v;
      ent = palette[dac_rd_entry];
      case (dac_rd_phase)
        vrd_pkg::PHASE_RED: begin
          v = {2'b00, ent[17:12]};
          dac_rd_phase = vrd_pkg::PHASE_GREEN;
        end
        vrd_pkg::PHASE_GREEN: begin
          v = {2'b00, ent[11:6]};
          dac_rd_phase = vrd_pkg::PHASE_BLUE;
        end
        default: begin
          v = {2'b00, ent[5:0]};
          dac_rd_entry = (dac_rd_entry + 1) % PAL_N;
          dac_rd_phase = vrd_pkg::PHASE_RED;
        end
      endcase
      return v;
    endfunction

    function port_result_t predict(logic kind, logic [4:0] port, logic [7:0] wd);
      port_result_t r;
      logic         locked;
      r.read_data = '0;
      if (kind == vrd_pkg::KIND_WRITE) begin
        case (port)
          vrd_pkg::PORT_ATTR: begin
            if (!attr_flip) begin
              attr_idx = wd[5:0];
            end else if (attr_idx[4:0] < vrd_pkg::ATTR_DEPTH) begin
              attr_regs[attr_idx[4:0]] = wd;
            end
            attr_flip = ~attr_flip;
          end
          vrd_pkg::PORT_MISC_WR:  misc_reg = wd;
          vrd_pkg::PORT_SEQ_IDX:  seq_idx = wd;
          vrd_pkg::PORT_SEQ_DATA: if (seq_idx < vrd_pkg::SEQ_DEPTH) seq_regs[seq_idx] = wd;
          vrd_pkg::PORT_DAC_RIDX: begin
            dac_rd_entry = wd % PAL_N;
            dac_rd_phase = vrd_pkg::PHASE_RED;
          end
          vrd_pkg::PORT_DAC_WIDX: begin
            dac_wr_entry = wd % PAL_N;
            dac_wr_phase = vrd_pkg::PHASE_RED;
          end
          vrd_pkg::PORT_DAC_DATA: dac_load(wd[5:0]);
          vrd_pkg::PORT_GFX_IDX:  gfx_idx = wd;
          vrd_pkg::PORT_GFX_DATA: if (gfx_idx < vrd_pkg::GFX_DEPTH) gfx_regs[gfx_idx] = wd;
          vrd_pkg::PORT_CRTC_IDX: crtc_idx = wd;
          vrd_pkg::PORT_CRTC_DATA: begin
            locked = crtc_regs[vrd_pkg::CRTC_PROTECT_REG][vrd_pkg::CRTC_PROTECT_BIT];
            if (crtc_idx < vrd_pkg::CRTC_DEPTH &&
                !(locked && crtc_idx < vrd_pkg::CRTC_PROT_LIMIT)) begin
              crtc_regs[crtc_idx] = wd;
            end
          end
          default: ;
        endcase
      end else begin
        case (port)
          vrd_pkg::PORT_ATTR:     r.read_data = {2'b00, attr_idx};
          vrd_pkg::PORT_ATTR_RD: begin
            if (attr_idx[4:0] < vrd_pkg::ATTR_DEPTH) r.read_data = attr_regs[attr_idx[4:0]];
          end
          vrd_pkg::PORT_SEQ_IDX:  r.read_data = seq_idx;
          vrd_pkg::PORT_SEQ_DATA: begin
            if (seq_idx < vrd_pkg::SEQ_DEPTH) r.read_data = seq_regs[seq_idx];
          end
          vrd_pkg::PORT_DAC_WIDX: r.read_data = 8'(dac_wr_entry);
          vrd_pkg::PORT_DAC_DATA: r.read_data = dac_fetch();
          vrd_pkg::PORT_MISC_RD:  r.read_data = misc_reg;
          vrd_pkg::PORT_GFX_IDX:  r.read_data = gfx_idx;
          vrd_pkg::PORT_GFX_DATA: begin
            if (gfx_idx < vrd_pkg::GFX_DEPTH) r.read_data = gfx_regs[gfx_idx];
          end
          vrd_pkg::PORT_CRTC_IDX: r.read_data = crtc_idx;
          vrd_pkg::PORT_CRTC_DATA: begin
            if (crtc_idx < vrd_pkg::CRTC_DEPTH) r.read_data = crtc_regs[crtc_idx];
          end
          vrd_pkg::PORT_STATUS:   attr_flip = 1'b0;
          default: ;
        endcase
      end
      r.display_enabled = attr_idx[5];
      return r;
    endfunction

    function void note_access(logic kind, logic [4:0] port, logic [7:0] wd);
      expected_q.push_back(predict(kind, port, wd));
    endfunction

    task check_result(logic [7:0] rd, logic de);
      port_result_t exp_r;
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("result rd=%02h de=%0b with nothing outstanding", rd, de));
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (rd !== exp_r.read_data)
          log_mismatch($sformatf("read_data %02h, predicted %02h", rd, exp_r.read_data));
        if (de !== exp_r.display_enabled)
          log_mismatch($sformatf("display_enabled %0b, predicted %0b", de,
                                 exp_r.display_enabled));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // kind[0], port[5:1], write_data[13:6], zero[15:14]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // read_data[7:0], display_enabled[8], zero[15:9]

  port_scoreboard sb = new();

  int send_idle_pct = 38;
  int recv_idle_pct = 47;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int accesses = 0;
  int reads = 0;

  vga_register_file_and_dac_core #(
    .PALETTE_ENTRIES(PAL_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // receiver: random back-pressure plus one long hold-off to fill the block
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[7:0], out_tdata[8]);
  end

  task automatic send_access(logic kind, logic [4:0] port, logic [7:0] wd);
    // never point a DAC read at an entry that was not loaded
    if (kind == vrd_pkg::KIND_READ && port == vrd_pkg::PORT_DAC_DATA && !sb.fetch_ok())
      port = vrd_pkg::PORT_DAC_WIDX;
    if (accesses < ITEMS / 3) begin
      send_idle_pct = 38;
      recv_idle_pct = 47;
    end else if (accesses < 2 * ITEMS / 3) begin
      send_idle_pct = 47;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 1'b1;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, wd, port, kind};
    do @(posedge clk); while (!in_tready);
    sb.note_access(kind, port, wd);
    accesses++;
    if (kind == vrd_pkg::KIND_READ) reads++;
  endtask

  task automatic run_directed();
    // attribute index with top bits set, then out-of-range data
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_ATTR, 8'hFF);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_ATTR, 8'hA5);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_ATTR_RD, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_ATTR, 8'h34);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_ATTR, 8'hFF);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_ATTR_RD, 8'h00);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_ATTR, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_MISC_WR, 8'hFF);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_MISC_RD, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_SEQ_IDX, 8'h04);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_SEQ_DATA, 8'h81);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_SEQ_DATA, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_SEQ_IDX, 8'hFF);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_SEQ_DATA, 8'h00);
    // lock the low CRTC registers, then try to write one
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_CRTC_IDX, vrd_pkg::CRTC_PROTECT_REG);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_CRTC_DATA, 8'h80);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_CRTC_IDX, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_CRTC_DATA, 8'h55);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_CRTC_DATA, 8'h00);
    // last palette entry, wrap of the write pointer, read back
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_WIDX, 8'hFF);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_DATA, 8'hFF);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_DATA, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_DATA, 8'hC1);
    send_access(vrd_pkg::KIND_READ,  vrd_pkg::PORT_DAC_WIDX, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_RIDX, 8'hFF);
    repeat (3) send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_DAC_DATA, 8'h00);
    send_access(vrd_pkg::KIND_WRITE, PORT_UNMAPPED, 8'hFF);
    send_access(vrd_pkg::KIND_READ,  PORT_UNMAPPED, 8'h00);
  endtask

  task automatic bank_sequence(logic [4:0] idx_port, logic [4:0] data_port, int idx_span);
    logic [7:0] idx;
    idx = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, idx_span));
    send_access(vrd_pkg::KIND_WRITE, idx_port, idx);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0, 1:    send_access(vrd_pkg::KIND_WRITE, data_port, 8'($urandom));
        2:       send_access(vrd_pkg::KIND_READ, data_port, 8'($urandom));
        default: send_access(vrd_pkg::KIND_READ, idx_port, 8'($urandom));
      endcase
    end
  endtask

  task automatic dac_load_run();
    send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_WIDX, 8'($urandom));
    repeat ($urandom_range(2, 9))
      send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_DATA, 8'($urandom));
  endtask

  task automatic random_pattern();
    access_pattern_t pat;
    logic [7:0]      idx;
    if ($urandom_range(0, 99) < 15) begin
      send_access(1'($urandom), 5'($urandom), 8'($urandom));
    end else begin
      pat = access_pattern_t'($urandom_range(0, 6));
      case (pat)
        PAT_SEQ_BANK: bank_sequence(vrd_pkg::PORT_SEQ_IDX, vrd_pkg::PORT_SEQ_DATA, 7);
        PAT_GFX_BANK: bank_sequence(vrd_pkg::PORT_GFX_IDX, vrd_pkg::PORT_GFX_DATA, 11);
        PAT_CRTC_BANK: begin
          if ($urandom_range(0, 3) == 0) begin
            send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_CRTC_IDX,
                        vrd_pkg::CRTC_PROTECT_REG);
            send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_CRTC_DATA, 8'($urandom));
          end
          bank_sequence(vrd_pkg::PORT_CRTC_IDX, vrd_pkg::PORT_CRTC_DATA, 31);
        end
        PAT_ATTR: begin
          // status read usually resyncs the flip-flop; sometimes left out on purpose
          if ($urandom_range(0, 4) != 0)
            send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_STATUS, 8'($urandom));
          idx = 8'($urandom);
          if ($urandom_range(0, 2) != 0) idx[4:0] = 5'($urandom_range(0, 20));
          send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_ATTR, idx);
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
              0:       send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_ATTR, 8'($urandom));
              1:       send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_ATTR_RD, 8'($urandom));
              default: send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_ATTR, 8'($urandom));
            endcase
          end
        end
        PAT_DAC_LOAD: dac_load_run();
        PAT_DAC_FETCH: begin
          if (sb.loaded_q.size() == 0) begin
            dac_load_run();
          end else begin
            idx = 8'(sb.loaded_q[$urandom_range(0, sb.loaded_q.size() - 1)]);
            send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_DAC_RIDX, idx);
            repeat ($urandom_range(1, 6))
              send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_DAC_DATA, 8'($urandom));
            if ($urandom_range(0, 3) == 0)
              send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_DAC_WIDX, 8'($urandom));
          end
        end
        default: begin
          send_access(vrd_pkg::KIND_WRITE, vrd_pkg::PORT_MISC_WR, 8'($urandom));
          send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_MISC_RD, 8'($urandom));
          if ($urandom_range(0, 2) == 0)
            send_access(vrd_pkg::KIND_READ, vrd_pkg::PORT_MISC_WR, 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (accesses < ITEMS) random_pattern();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d port accesses (%0d reads), %0d palette entries loaded,",
             accesses, reads, sb.loaded_q.size());
    $display("random stalls on both sides and one long output hold-off; %0d results, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
src/vrd_pkg.sv
src/vrd_regbank.sv
src/vrd_palette.sv
src/vga_register_file_and_dac_core.sv
sim/testbench.sv
